@@ rtl/assert_macros.svh @@
// Assertion macros for the texture mask block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define MLVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mlvt assertion failed");
// Checked at every edge, reset included.
`define MLVT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mlvt assertion failed");
`else
`define MLVT_ASSERT(lbl, prop)
`define MLVT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/mlvt_pkg.sv @@
// Shared types, constants and helpers for the texture mask block.
package mlvt_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int PIX_IDX_W  = 20;
  localparam int DIV_STEPS  = PIX_IDX_W;
  localparam int ENTRY_W    = 9;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [7:0]       THR_RST    = 8'd3;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_VAR_THRESH   = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_addr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_SHIFT,
    ST_ACC,
    ST_MUL,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_value;
    logic       in_mask;
  } in_item_t;

  typedef struct packed {
    logic             textured;
    logic [COL_W-1:0] out_col;
    logic [COL_W-1:0] out_row;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic start;
    logic div_step;
    logic shift;
    logic acc_step;
    logic mul;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic need_div;
    logic div_done;
    logic has_result;
    logic acc_done;
    logic out_busy;
  } status_t;

  // Window slot of neighbor k, skipping the center slot.
  function automatic logic [3:0] nb_pos(input logic [2:0] k);
    nb_pos = (k < 3'd4) ? {1'b0, k} : ({1'b0, k} + 4'd1);
  endfunction

  // n*n for a neighbor count of 0..8.
  function automatic logic [6:0] count_sq(input logic [3:0] n);
    case (n)
      4'd1:    count_sq = 7'd1;
      4'd2:    count_sq = 7'd4;
      4'd3:    count_sq = 7'd9;
      4'd4:    count_sq = 7'd16;
      4'd5:    count_sq = 7'd25;
      4'd6:    count_sq = 7'd36;
      4'd7:    count_sq = 7'd49;
      4'd8:    count_sq = 7'd64;
      default: count_sq = 7'd0;
    endcase
  endfunction

endpackage

@@ rtl/mlvt_ram.sv @@
// Generic single-write, single-read RAM with registered read.
module mlvt_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mlvt_ctrl.sv @@
// Sequencer for the texture mask block.
module mlvt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mlvt_pkg::status_t sts,
  output mlvt_pkg::cmd_t    cmd,
  output mlvt_pkg::state_t  state
);

  mlvt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlvt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlvt_pkg::ST_IDLE:  if (in_valid) state_nxt = mlvt_pkg::ST_START;
      mlvt_pkg::ST_START: begin
        if (sts.skip)          state_nxt = mlvt_pkg::ST_IDLE;
        else if (sts.need_div) state_nxt = mlvt_pkg::ST_DIV;
        else                   state_nxt = mlvt_pkg::ST_SHIFT;
      end
      mlvt_pkg::ST_DIV:   if (sts.div_done) state_nxt = mlvt_pkg::ST_SHIFT;
      mlvt_pkg::ST_SHIFT: begin
        state_nxt = sts.has_result ? mlvt_pkg::ST_ACC : mlvt_pkg::ST_IDLE;
      end
      mlvt_pkg::ST_ACC:   if (sts.acc_done) state_nxt = mlvt_pkg::ST_MUL;
      mlvt_pkg::ST_MUL:   state_nxt = mlvt_pkg::ST_CMP;
      mlvt_pkg::ST_CMP:   if (!sts.out_busy) state_nxt = mlvt_pkg::ST_IDLE;
      default:            state_nxt = mlvt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      mlvt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mlvt_pkg::ST_START: cmd.start    = 1'b1;
      mlvt_pkg::ST_DIV:   cmd.div_step = 1'b1;
      mlvt_pkg::ST_SHIFT: cmd.shift    = 1'b1;
      mlvt_pkg::ST_ACC:   cmd.acc_step = 1'b1;
      mlvt_pkg::ST_MUL:   cmd.mul      = 1'b1;
      mlvt_pkg::ST_CMP:   cmd.finish   = !sts.out_busy;
      default: ;
    endcase
  end

  assign state = state_r;

endmodule

@@ rtl/mlvt_datapath.sv @@
// Datapath: config, line stores, window, counters, variance test, result register.
module mlvt_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mlvt_pkg::in_item_t   in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [10:0]          cfg_data,
  input  mlvt_pkg::cmd_t       cmd,
  output mlvt_pkg::status_t    sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mlvt_pkg::out_item_t  out_data
);

  localparam int CW = mlvt_pkg::COL_W;
  localparam int DW = mlvt_pkg::DIM_W;
  localparam int PW = mlvt_pkg::PIX_IDX_W;
  localparam int EW = mlvt_pkg::ENTRY_W;

  // config
  logic [DW-1:0] width_r, height_r;
  logic [7:0]    thr_r;
  logic          dirty_r, dirty_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mlvt_pkg::WIDTH_RST;
      height_r <= mlvt_pkg::HEIGHT_RST;
      thr_r    <= mlvt_pkg::THR_RST;
    end else if (cfg_we) begin
      unique case (mlvt_pkg::cfg_addr_t'(cfg_addr))
        mlvt_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_data;
        mlvt_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_data;
        mlvt_pkg::CFG_VAR_THRESH:   thr_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w, h;
  always_comb begin
    w = width_r;
    if (w == '0) w = DW'(1);
    else if (w > DW'(mlvt_pkg::MAX_WIDTH)) w = DW'(mlvt_pkg::MAX_WIDTH);
    h = height_r;
    if (h == '0) h = DW'(1);
    else if (h > DW'(mlvt_pkg::MAX_HEIGHT)) h = DW'(mlvt_pkg::MAX_HEIGHT);
  end

  logic [2*DW-1:0] frame_size;
  assign frame_size = (2*DW)'(w) * (2*DW)'(h);

  // state registers
  mlvt_pkg::in_item_t item_r;
  logic [CW-1:0]  in_col_r, in_col_nxt;
  logic [DW-1:0]  in_row_r, in_row_nxt;
  logic [PW-1:0]  pidx_r, pidx_nxt;
  logic [CW-1:0]  ocol_r, ocol_nxt, orow_r, orow_nxt;
  logic [EW-1:0]  win_r [9];
  logic [PW-1:0]  dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [4:0]     dcnt_r, dcnt_nxt;
  logic [2:0]     k_r, k_nxt;
  logic [3:0]     n_r, n_nxt;
  logic signed [11:0] s_r, s_nxt;
  logic [19:0]    q_r, q_nxt;
  logic [23:0]    nq_r, ss_r;
  logic [14:0]    tn_r;
  logic           ov_r, ov_nxt;
  mlvt_pkg::out_item_t od_r, od_nxt;

  // line stores
  logic [EW-1:0] up_rd, mid_rd, entry;
  logic          restart;
  logic [CW-1:0] rd_addr;

  assign restart = {1'b0, pidx_r} >= PW'(0) + frame_size[PW:0];
  assign rd_addr = restart ? '0 : in_col_r;
  assign entry   = (!item_r.mode && in_row_r < h) ? {item_r.in_mask, item_r.pixel_value} : '0;

  mlvt_ram #(.WIDTH(EW), .DEPTH(mlvt_pkg::MAX_WIDTH)) u_upper (
    .clk(clk), .we(cmd.shift), .waddr(in_col_r), .wdata(mid_rd),
    .re(cmd.start), .raddr(rd_addr), .rdata(up_rd)
  );
  mlvt_ram #(.WIDTH(EW), .DEPTH(mlvt_pkg::MAX_WIDTH)) u_middle (
    .clk(clk), .we(cmd.shift), .waddr(in_col_r), .wdata(entry),
    .re(cmd.start), .raddr(rd_addr), .rdata(mid_rd)
  );

  // arrival index and result test
  logic [2*DW:0] arrival;
  assign arrival = (2*DW+1)'(in_row_r) * (2*DW+1)'(w) + (2*DW+1)'(in_col_r);

  // divider step
  logic [DW:0] rem_sh;
  assign rem_sh = {rem_r, dvd_r[PW-1]};

  // neighbor select and difference
  logic [3:0] pos;
  logic [EW-1:0] nb, ctr;
  logic          in_frame;
  logic signed [9:0]  d;
  logic [19:0]   dsq;
  assign pos = mlvt_pkg::nb_pos(k_r);
  assign nb  = win_r[pos];
  assign ctr = win_r[4];
  assign d   = $signed({2'b00, nb[7:0]}) - $signed({2'b00, ctr[7:0]});
  assign dsq = 20'(20'(d) * 20'(d));

  always_comb begin
    in_frame = 1'b1;
    if (pos < 4'd3 && orow_r == '0) in_frame = 1'b0;
    if (pos > 4'd5 && ({1'b0, orow_r} + DW'(1)) >= h) in_frame = 1'b0;
    if ((pos == 4'd0 || pos == 4'd3 || pos == 4'd6) && ocol_r == '0) in_frame = 1'b0;
    if ((pos == 4'd2 || pos == 4'd5 || pos == 4'd8) && ({1'b0, ocol_r} + DW'(1)) >= w)
      in_frame = 1'b0;
  end

  logic [24:0] ss_tn;
  logic [PW:0] pidx_inc;
  logic        last;
  assign ss_tn    = {1'b0, ss_r} + 25'(tn_r);
  assign pidx_inc = {1'b0, pidx_r} + (PW+1)'(1);
  assign last     = (PW+1)'(0) + pidx_inc >= frame_size[PW:0];

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    pidx_nxt   = pidx_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    dirty_nxt  = dirty_r;
    dvd_nxt    = dvd_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    s_nxt      = s_r;
    q_nxt      = q_r;
    ov_nxt     = ov_r;
    od_nxt     = od_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (cfg_we && mlvt_pkg::cfg_addr_t'(cfg_addr) == mlvt_pkg::CFG_FRAME_WIDTH)
      dirty_nxt = 1'b1;
    if (cmd.start) begin
      dvd_nxt  = pidx_r;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dcnt_nxt = '0;
      if (restart) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        pidx_nxt   = '0;
        ocol_nxt   = '0;
        orow_nxt   = '0;
        dirty_nxt  = 1'b0;
      end
    end
    if (cmd.div_step) begin
      dvd_nxt  = {dvd_r[PW-2:0], 1'b0};
      dcnt_nxt = dcnt_r + 5'd1;
      if (rem_sh >= {1'b0, w}) begin
        rem_nxt = DW'(rem_sh - {1'b0, w});
        quo_nxt = {quo_r[PW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DW-1:0];
        quo_nxt = {quo_r[PW-2:0], 1'b0};
      end
      if (dcnt_r == 5'(mlvt_pkg::DIV_STEPS - 1)) begin
        orow_nxt  = quo_nxt[CW-1:0];
        ocol_nxt  = rem_nxt[CW-1:0];
        dirty_nxt = 1'b0;
      end
    end
    if (cmd.shift) begin
      if (({1'b0, in_col_r} + DW'(1)) >= w) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + DW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      k_nxt = '0;
      n_nxt = '0;
      s_nxt = '0;
      q_nxt = '0;
    end
    if (cmd.acc_step) begin
      k_nxt = k_r + 3'd1;
      if (in_frame && nb[8]) begin
        n_nxt = n_r + 4'd1;
        s_nxt = s_r + 12'(d);
        q_nxt = q_r + dsq;
      end
    end
    if (cmd.finish) begin
      ov_nxt = 1'b1;
      od_nxt.textured   = ctr[8] && (n_r != '0) && ({1'b0, nq_r} > ss_tn);
      od_nxt.out_col    = ocol_r;
      od_nxt.out_row    = orow_r;
      od_nxt.frame_last = last;
      if (last) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        pidx_nxt   = '0;
        ocol_nxt   = '0;
        orow_nxt   = '0;
      end else begin
        pidx_nxt = pidx_inc[PW-1:0];
        if (({1'b0, ocol_r} + DW'(1)) >= w) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + CW'(1);
        end else begin
          ocol_nxt = ocol_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      pidx_r   <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
      dirty_r  <= 1'b0;
      ov_r     <= 1'b0;
      k_r      <= '0;
      dcnt_r   <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      pidx_r   <= pidx_nxt;
      ocol_r   <= ocol_nxt;
      orow_r   <= orow_nxt;
      dirty_r  <= dirty_nxt;
      ov_r     <= ov_nxt;
      k_r      <= k_nxt;
      dcnt_r   <= dcnt_nxt;
      if (cmd.shift) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i*3]   <= win_r[i*3+1];
          win_r[i*3+1] <= win_r[i*3+2];
        end
        win_r[2] <= up_rd;
        win_r[5] <= mid_rd;
        win_r[8] <= entry;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    n_r   <= n_nxt;
    s_r   <= s_nxt;
    q_r   <= q_nxt;
    od_r  <= od_nxt;
    if (cmd.mul) begin
      nq_r <= 24'(24'(n_r) * 24'(q_r));
      ss_r <= 24'(24'(s_r) * 24'(s_r));
      tn_r <= 15'(15'(thr_r) * 15'(mlvt_pkg::count_sq(n_r)));
    end
  end

  assign sts.skip       = item_r.mode && (restart || (in_col_r == '0 && in_row_r == '0));
  assign sts.need_div   = dirty_r && !restart;
  assign sts.div_done   = dcnt_r == 5'(mlvt_pkg::DIV_STEPS - 1);
  assign sts.has_result = arrival >= (2*DW+1)'({1'b0, w} + (DW+1)'(1));
  assign sts.acc_done   = k_r == 3'd7;
  assign sts.out_busy   = ov_r && !out_ready;

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

@@ rtl/masked_local_variance_texture_mask_unit.sv @@
// Top level of the masked 3x3 local variance texture mask.
// Flow: one input item in flight; a new transfer is taken only once the sequencer is back in
//   idle, which waits while out is stalled or the divider runs after a frame_width write.
// Results lag input by one row plus one pixel; each result passes the 8-step neighbor
//   accumulator in the datapath.
// Reset (rst_n low, synchronous): counters, window, config to defaults; line stores undefined.
`include "assert_macros.svh"

module masked_local_variance_texture_mask_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mlvt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mlvt_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_addr,
  input  logic [10:0]          cfg_data
);

  mlvt_pkg::cmd_t    cmd;
  mlvt_pkg::status_t sts;
  mlvt_pkg::state_t  state;

  // config writes are always taken; the user must send them only while idle (not enforced here)
  assign cfg_ready = 1'b1;

  mlvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  mlvt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // one item in flight: no second transfer right after one
  `MLVT_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready)
  // a result is only loaded from the compare step
  `MLVT_ASSERT(a_out_from_cmp, $rose(out_valid) |-> ($past(state) == mlvt_pkg::ST_CMP))
  // reset empties the result register
  `MLVT_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid)

endmodule

@@ bench/masked_local_variance_texture_mask_unit_test.sv @@
// Self-checking testbench for the masked 3x3 local variance texture mask unit.
`timescale 1ns / 100ps

module masked_local_variance_texture_mask_unit_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int ITEM_TARGET    = 980;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  mlvt_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  mlvt_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  mlvt_pkg::cfg_addr_t cfg_addr;
  logic [10:0]         cfg_data;

  masked_local_variance_texture_mask_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Pixel stream waiting to be sent, and mask results waiting to arrive.
  mlvt_pkg::in_item_t  pixel_fifo[$];
  mlvt_pkg::out_item_t mask_fifo[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned pixels_sent;
  int unsigned flushes_sent;
  int unsigned results_seen;
  int unsigned textured_seen;
  int unsigned frames_sent;
  int unsigned idle_count;
  int unsigned items_queued;

  // Quiet stretch: no idling from either side in the first quarter of each cycle_count period.
  function automatic bit take_gap();
    if ((cycle_count % 8000) < 2000) return 1'b0;
    return ($urandom_range(0, 99) < 16);
  endfunction

  //--------------------------------------------------------------------------
  // Behavioral copy of the block: registers, line stores, window, counters.
  //--------------------------------------------------------------------------
  logic [10:0] shadow_width;
  logic [10:0] shadow_height;
  logic [7:0]  shadow_thresh;
  logic [8:0]  upper_line[mlvt_pkg::MAX_WIDTH];
  logic [8:0]  middle_line[mlvt_pkg::MAX_WIDTH];
  logic [8:0]  win[9];
  int unsigned arr_col;
  int unsigned arr_row;
  int unsigned next_out_idx;

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Variance test over the in-frame, masked neighbors of the window center.
  function automatic bit texture_decision(input int unsigned r, input int unsigned c,
                                          input int unsigned w, input int unsigned h);
    longint n, s, q, d;
    n = 0;
    s = 0;
    q = 0;
    if (!win[4][8]) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i == 1 && j == 1) continue;
        if (i == 0 && r == 0) continue;
        if (i == 2 && r + 1 >= h) continue;
        if (j == 0 && c == 0) continue;
        if (j == 2 && c + 1 >= w) continue;
        if (!win[i*3+j][8]) continue;
        d = longint'(win[i*3+j][7:0]) - longint'(win[4][7:0]);
        n += 1;
        s += d;
        q += d * d;
      end
    end
    if (n == 0) return 1'b0;
    return (n * q - s * s > longint'(shadow_thresh) * n * n);
  endfunction

  task automatic restart_counters();
    arr_col = 0;
    arr_row = 0;
    next_out_idx = 0;
  endtask

  task automatic shadow_reset();
    shadow_width  = mlvt_pkg::WIDTH_RST;
    shadow_height = mlvt_pkg::HEIGHT_RST;
    shadow_thresh = mlvt_pkg::THR_RST;
    foreach (upper_line[k]) upper_line[k] = '0;
    foreach (middle_line[k]) middle_line[k] = '0;
    foreach (win[k]) win[k] = '0;
    restart_counters();
  endtask

  // Advance the copy by one accepted input transfer; queue the result if any.
  task automatic predict_mask(input mlvt_pkg::in_item_t it);
    int unsigned w, h, col, arrival, p;
    logic [8:0] entry;
    mlvt_pkg::out_item_t res;
    w = clamp_dim(shadow_width, mlvt_pkg::MAX_WIDTH);
    h = clamp_dim(shadow_height, mlvt_pkg::MAX_HEIGHT);
    if (next_out_idx >= w * h) restart_counters();
    if (it.mode && arr_col == 0 && arr_row == 0) return;  // flush at frame start
    entry = (!it.mode && arr_row < h) ? {it.in_mask, it.pixel_value} : 9'd0;
    col = (arr_col >= mlvt_pkg::MAX_WIDTH) ? mlvt_pkg::MAX_WIDTH - 1 : arr_col;
    for (int i = 0; i < 3; i++) begin
      win[i*3+0] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = upper_line[col];
    win[5] = middle_line[col];
    win[8] = entry;
    upper_line[col]  = middle_line[col];
    middle_line[col] = entry;
    arrival = arr_row * w + arr_col;
    if (arr_col + 1 >= w) begin
      arr_col = 0;
      arr_row++;
    end else begin
      arr_col++;
    end
    if (arrival >= w + 1) begin
      p = next_out_idx;
      res.textured   = texture_decision(p / w, p % w, w, h);
      res.out_col    = 10'(p % w);
      res.out_row    = 10'(p / w);
      res.frame_last = (p + 1 >= w * h);
      mask_fifo = {mask_fifo, res};
      if (res.frame_last) restart_counters();
      else next_out_idx = p + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH @%0t result %0d: %s got %0d expected %0d",
             $realtime, results_seen, what, got, want);
    mismatch_count++;
  endtask

  //--------------------------------------------------------------------------
  // Driver: one transfer per handshake, fed from pixel_fifo.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_mask(in_data);
        if (in_data.mode) flushes_sent++;
        else pixels_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pixel_fifo.size() > 0 && !take_gap()) begin
          in_valid <= 1'b1;
          in_data  <= pixel_fifo.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest prediction.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (mask_fifo.size() == 0) begin
          report_mismatch("unexpected result, row", out_data.out_row, 0);
        end else begin
          mlvt_pkg::out_item_t want;
          want = mask_fifo.pop_front();
          if (out_data.textured !== want.textured)
            report_mismatch("textured", out_data.textured, want.textured);
          if (out_data.out_col !== want.out_col)
            report_mismatch("out_col", out_data.out_col, want.out_col);
          if (out_data.out_row !== want.out_row)
            report_mismatch("out_row", out_data.out_row, want.out_row);
          if (out_data.frame_last !== want.frame_last)
            report_mismatch("frame_last", out_data.frame_last, want.frame_last);
          if (out_data.textured) textured_seen++;
        end
      end
      out_ready <= !take_gap();
    end
  end

  // Watchdog: any transfer restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("masked_local_variance_texture_mask_unit verification failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus
  //--------------------------------------------------------------------------
  task automatic queue_item(input mlvt_pkg::in_item_t it);
    pixel_fifo = {pixel_fifo, it};
    items_queued++;
  endtask

  // Holds cfg_valid high; the caller drops it after its last write.
  task automatic write_reg(input mlvt_pkg::cfg_addr_t addr, input logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      mlvt_pkg::CFG_FRAME_WIDTH:  shadow_width  = value;
      mlvt_pkg::CFG_FRAME_HEIGHT: shadow_height = value;
      mlvt_pkg::CFG_VAR_THRESH:   shadow_thresh = value[7:0];
      default: ;
    endcase
  endtask

  // Block goes idle: everything sent, every result back, then the pipe settles.
  task automatic wait_drained();
    while (pixel_fifo.size() > 0 || in_valid || mask_fifo.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input logic [10:0] w, input logic [10:0] h,
                           input logic [7:0] thr);
    wait_drained();
    write_reg(mlvt_pkg::CFG_FRAME_WIDTH, w);
    write_reg(mlvt_pkg::CFG_FRAME_HEIGHT, h);
    write_reg(mlvt_pkg::CFG_VAR_THRESH, {3'b000, thr});
    cfg_valid <= 1'b0;
  endtask

  function automatic mlvt_pkg::in_item_t pixel(input logic [7:0] v, input logic m);
    mlvt_pkg::in_item_t it;
    it.mode        = 1'b0;
    it.pixel_value = v;
    it.in_mask     = m;
    return it;
  endfunction

  function automatic mlvt_pkg::in_item_t flush_tick();
    mlvt_pkg::in_item_t it;
    it.mode        = 1'b1;
    it.pixel_value = 8'($urandom_range(0, 255));
    it.in_mask     = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // One whole frame plus the drain, sized for the current register values.
  // Noisy frames get flush ticks inside the frame and pixels while draining.
  task automatic queue_frame(input bit noisy);
    int unsigned w, h;
    logic [7:0] base, v;
    w = clamp_dim(shadow_width, mlvt_pkg::MAX_WIDTH);
    h = clamp_dim(shadow_height, mlvt_pkg::MAX_HEIGHT);
    base = 8'($urandom_range(0, 255));
    for (int unsigned k = 0; k < w * h; k++) begin
      if (noisy && k > 0 && $urandom_range(0, 99) < 6) begin
        queue_item(flush_tick());
      end else begin
        if ($urandom_range(0, 1)) v = base + 8'($urandom_range(0, 5));
        else v = 8'($urandom_range(0, 255));
        queue_item(pixel(v, $urandom_range(0, 99) < 85));
      end
    end
    for (int unsigned k = 0; k < w + 1; k++) begin
      if (noisy && $urandom_range(0, 3) == 0)
        queue_item(pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      else
        queue_item(flush_tick());
    end
    // Flushes at frame start are dropped without a result.
    if (noisy && $urandom_range(0, 1)) queue_item(flush_tick());
    frames_sent++;
  endtask

  initial begin
    logic [7:0] thr;
    rst_n          = 1'b0;
    cycle_count    = 0;
    mismatch_count = 0;
    pixels_sent    = 0;
    flushes_sent   = 0;
    results_seen   = 0;
    textured_seen  = 0;
    frames_sent    = 0;
    idle_count     = 0;
    items_queued   = 0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_addr       = mlvt_pkg::CFG_FRAME_WIDTH;
    cfg_data       = '0;
    shadow_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed 3x3 frame: full-scale values, unmasked center, isolated pixel,
    // a flush before the frame, a flush inside and a pixel while draining.
    set_frame(11'd3, 11'd3, 8'd0);
    queue_item(flush_tick());
    queue_item(pixel(8'd0,   1'b1));
    queue_item(pixel(8'd255, 1'b1));
    queue_item(pixel(8'd0,   1'b1));
    queue_item(pixel(8'd255, 1'b1));
    queue_item(pixel(8'd128, 1'b0));
    queue_item(pixel(8'd255, 1'b1));
    queue_item(pixel(8'd0,   1'b1));
    queue_item(flush_tick());
    queue_item(pixel(8'd7,   1'b1));
    queue_item(pixel(8'd9,   1'b1));
    queue_item(flush_tick());
    queue_item(pixel(8'd77,  1'b1));
    queue_item(flush_tick());
    queue_item(flush_tick());
    queue_item(flush_tick());
    // A random 3x2 frame with the top threshold; isolated masked pixel in a 1x1 frame.
    set_frame(11'd3, 11'd2, 8'd255);
    queue_frame(1'b0);
    set_frame(11'd1, 11'd1, 8'd3);
    queue_item(pixel(8'd200, 1'b1));
    queue_item(flush_tick());
    queue_item(flush_tick());

    // Zero size acts as one.
    set_frame(11'd0, 11'd0, 8'd0);
    queue_frame(1'b1);

    // Random phases of small frames.
    while (items_queued < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        default: thr = 8'($urandom_range(0, 40));
      endcase
      set_frame(11'($urandom_range(1, 12)), 11'($urandom_range(1, 8)), thr);
      repeat ($urandom_range(1, 2)) queue_frame($urandom_range(0, 3) != 0);
    end

    wait_drained();
    $display("covered %0d frames: %0d pixels, %0d flush ticks, %0d results (%0d textured)",
             frames_sent, pixels_sent, flushes_sent, results_seen, textured_seen);
    if (mismatch_count == 0) begin
      $display("masked_local_variance_texture_mask_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("masked_local_variance_texture_mask_unit verification failed");
    end
    $finish;
  end

endmodule
